### hdl/imu_bw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_bw_pkg
// Types, fixed-point constants and the round/saturate helper for the IMU
// Butterworth low-pass filters.
// ----------------------------------------------------------------------------
package imu_bw_pkg;

   localparam int SAMPLE_WIDTH = 24;
   localparam int AXES         = 3;
   localparam int MAX_AXES     = 3;

   localparam int COEF_W    = 32;
   localparam int FRAC_BITS = 30;
   localparam int ACC_W     = SAMPLE_WIDTH + COEF_W + 3;
   localparam int RND_W     = ACC_W - FRAC_BITS;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic signed [COEF_W-1:0]       coef_type;
   typedef logic signed [ACC_W-1:0]        acc_type;
   typedef logic signed [RND_W-1:0]        rnd_type;

   // Q2.30 coefficients; feedback terms are stored already negated
   localparam coef_type GYRO_A0  =  32'sd72429549;
   localparam coef_type GYRO_A1  =  32'sd144859098;
   localparam coef_type GYRO_NB1 =  32'sd1227265970;
   localparam coef_type GYRO_NB2 = -32'sd443242341;

   localparam coef_type ACCEL_C0  =  32'sd19433581;
   localparam coef_type ACCEL_C1  =  32'sd58300744;
   localparam coef_type ACCEL_ND1 =  32'sd1889830579;
   localparam coef_type ACCEL_ND2 = -32'sd1270121969;
   localparam coef_type ACCEL_ND3 =  32'sd298564563;

   localparam acc_type ACC_HALF = acc_type'(longint'(1) <<< (FRAC_BITS - 1));
   localparam rnd_type RND_MAX  =
      rnd_type'((longint'(1) <<< (SAMPLE_WIDTH - 1)) - longint'(1));
   localparam rnd_type RND_MIN  = rnd_type'(-(longint'(1) <<< (SAMPLE_WIDTH - 1)));

   // round half up, then clamp to the sample range
   function automatic sample_type round_sat(input acc_type acc);
      acc_type biased;
      rnd_type q;
      biased = acc + ACC_HALF;
      q      = rnd_type'(biased >>> FRAC_BITS);
      if (q > RND_MAX) begin
         q = RND_MAX;
      end else if (q < RND_MIN) begin
         q = RND_MIN;
      end
      return sample_type'(q);
   endfunction

   function automatic acc_type mul(input sample_type s, input coef_type c);
      return acc_type'(s) * acc_type'(c);
   endfunction

endpackage

### hdl/imu_bw_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_bw_channels
// Valid/ready channel interfaces for the sample request and filtered response.
// ----------------------------------------------------------------------------
interface imu_bw_req_if import imu_bw_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type gyro_x;
   sample_type gyro_y;
   sample_type gyro_z;
   sample_type accel_x;
   sample_type accel_y;
   sample_type accel_z;

   modport source (output valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
                   input ready);
   modport sink   (input valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
                   output ready);
endinterface

interface imu_bw_rsp_if import imu_bw_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type gyro_filt_x;
   sample_type gyro_filt_y;
   sample_type gyro_filt_z;
   sample_type accel_filt_x;
   sample_type accel_filt_y;
   sample_type accel_filt_z;

   modport source (output valid, gyro_filt_x, gyro_filt_y, gyro_filt_z,
                   accel_filt_x, accel_filt_y, accel_filt_z, input ready);
   modport sink   (input valid, gyro_filt_x, gyro_filt_y, gyro_filt_z,
                   accel_filt_x, accel_filt_y, accel_filt_z, output ready);
endinterface

### hdl/imu_butterworth_lowpass_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_butterworth_lowpass_top
// 20 Hz Butterworth low-pass for three gyro and three accelerometer axes.
//
// A request carries one Q12.12 sample set on req_chan (valid/ready); the
// response on rsp_chan carries the six filtered, saturated values. Gyro axes
// use a second-order section, accelerometer axes a third-order one.
// An accepted request enters the input register, its filtered result the
// result register that drives the response. Throughput: one request per cycle
// while rsp ready is high, bounded by the combinational multiply-accumulate
// of each axis, whose recursive feedback term needs the previous result.
// A request is taken while a finished response still waits, as long as the
// result register is free to advance; when the receiver holds rsp ready low,
// one request is held in the input register and then req ready drops.
// Synchronous reset clears all filter histories and both valid flags.
// ----------------------------------------------------------------------------
module imu_butterworth_lowpass_top import imu_bw_pkg::*; (
   input logic         clock,
   input logic         reset,
   imu_bw_req_if.sink   req_chan,
   imu_bw_rsp_if.source rsp_chan
);

   logic       in_valid_ff,  in_valid_in;
   logic       out_valid_ff, out_valid_in;
   logic       take;
   logic       advance;

   sample_type gyro_req   [MAX_AXES];
   sample_type accel_req  [MAX_AXES];
   sample_type gyro_in_ff [MAX_AXES];
   sample_type accel_in_ff[MAX_AXES];
   sample_type gyro_in_in [MAX_AXES];
   sample_type accel_in_in[MAX_AXES];
   sample_type gyro_y     [MAX_AXES];
   sample_type accel_y    [MAX_AXES];
   sample_type gyro_out_ff [MAX_AXES];
   sample_type accel_out_ff[MAX_AXES];
   sample_type gyro_out_in [MAX_AXES];
   sample_type accel_out_in[MAX_AXES];

   assign advance = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign take = req_chan.valid && req_chan.ready;

   assign gyro_req  = '{req_chan.gyro_x, req_chan.gyro_y, req_chan.gyro_z};
   assign accel_req = '{req_chan.accel_x, req_chan.accel_y, req_chan.accel_z};

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      gyro_in_in   = gyro_in_ff;
      accel_in_in  = accel_in_ff;
      gyro_out_in  = gyro_out_ff;
      accel_out_in = accel_out_ff;
      if (advance) begin
         in_valid_in  = 1'b0;
         out_valid_in = 1'b1;
         gyro_out_in  = gyro_y;
         accel_out_in = accel_y;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      if (take) begin
         in_valid_in = 1'b1;
         gyro_in_in  = gyro_req;
         accel_in_in = accel_req;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      gyro_in_ff   <= gyro_in_in;
      accel_in_ff  <= accel_in_in;
      gyro_out_ff  <= gyro_out_in;
      accel_out_ff <= accel_out_in;
   end

   for (genvar i = 0; i < MAX_AXES; i++) begin : g_axis
      if (i < AXES) begin : g_on
         imu_bw_gyro_axis u_gyro (
            .clock   (clock),
            .reset   (reset),
            .advance (advance),
            .x       (gyro_in_ff[i]),
            .y       (gyro_y[i])
         );
         imu_bw_accel_axis u_accel (
            .clock   (clock),
            .reset   (reset),
            .advance (advance),
            .x       (accel_in_ff[i]),
            .y       (accel_y[i])
         );
      end else begin : g_off
         assign gyro_y[i]  = '0;
         assign accel_y[i] = '0;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.gyro_filt_x  = gyro_out_ff[0];
   assign rsp_chan.gyro_filt_y  = gyro_out_ff[1];
   assign rsp_chan.gyro_filt_z  = gyro_out_ff[2];
   assign rsp_chan.accel_filt_x = accel_out_ff[0];
   assign rsp_chan.accel_filt_y = accel_out_ff[1];
   assign rsp_chan.accel_filt_z = accel_out_ff[2];

endmodule

### hdl/imu_bw_gyro_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_bw_gyro_axis
// Second-order Butterworth low-pass, direct form I, one gyro axis.
// ----------------------------------------------------------------------------
module imu_bw_gyro_axis import imu_bw_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  sample_type x,
   output sample_type y
);

   sample_type x_hist_ff [2];
   sample_type y_hist_ff [2];
   sample_type x_hist_in [2];
   sample_type y_hist_in [2];
   acc_type    acc;

   always_comb begin
      acc = mul(x, GYRO_A0) + mul(x_hist_ff[0], GYRO_A1) + mul(x_hist_ff[1], GYRO_A0)
          + mul(y_hist_ff[0], GYRO_NB1) + mul(y_hist_ff[1], GYRO_NB2);
      y   = round_sat(acc);
   end

   always_comb begin
      x_hist_in = x_hist_ff;
      y_hist_in = y_hist_ff;
      if (advance) begin
         x_hist_in[1] = x_hist_ff[0];
         x_hist_in[0] = x;
         y_hist_in[1] = y_hist_ff[0];
         y_hist_in[0] = y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_hist_ff <= '{default: '0};
         y_hist_ff <= '{default: '0};
      end else begin
         x_hist_ff <= x_hist_in;
         y_hist_ff <= y_hist_in;
      end
   end

endmodule

### hdl/imu_bw_accel_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_bw_accel_axis
// Third-order Butterworth low-pass, direct form I, one accelerometer axis.
// ----------------------------------------------------------------------------
module imu_bw_accel_axis import imu_bw_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  sample_type x,
   output sample_type y
);

   sample_type x_hist_ff [3];
   sample_type y_hist_ff [3];
   sample_type x_hist_in [3];
   sample_type y_hist_in [3];
   acc_type    acc;

   always_comb begin
      acc = mul(x, ACCEL_C0) + mul(x_hist_ff[0], ACCEL_C1)
          + mul(x_hist_ff[1], ACCEL_C1) + mul(x_hist_ff[2], ACCEL_C0)
          + mul(y_hist_ff[0], ACCEL_ND1) + mul(y_hist_ff[1], ACCEL_ND2)
          + mul(y_hist_ff[2], ACCEL_ND3);
      y   = round_sat(acc);
   end

   always_comb begin
      x_hist_in = x_hist_ff;
      y_hist_in = y_hist_ff;
      if (advance) begin
         x_hist_in[2] = x_hist_ff[1];
         x_hist_in[1] = x_hist_ff[0];
         x_hist_in[0] = x;
         y_hist_in[2] = y_hist_ff[1];
         y_hist_in[1] = y_hist_ff[0];
         y_hist_in[0] = y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_hist_ff <= '{default: '0};
         y_hist_ff <= '{default: '0};
      end else begin
         x_hist_ff <= x_hist_in;
         y_hist_ff <= y_hist_in;
      end
   end

endmodule

### tb/sv/imu_butterworth_lowpass_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_butterworth_lowpass_top_tb
// Sends inertial sample sets through the low-pass top level and checks each
// filtered response against an in-bench fixed-point model of the six
// Butterworth sections. Covers field extremes, step overshoot into
// saturation, random noise, sensor-like streams, output back-pressure and
// drained bursts, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module imu_butterworth_lowpass_top_tb;
   import imu_bw_pkg::*;

   localparam int    PERIOD_HALF = 6;
   localparam int    RUN_LIMIT   = 100000;
   localparam int    MAX_IDLE    = 10;
   localparam int    MAX_PRINTS  = 30;
   localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
   localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

   typedef struct {
      sample_type gyro [3];
      sample_type accel[3];
   } imu_set_type;

   logic clock;
   logic reset;

   imu_bw_req_if req_if ();
   imu_bw_rsp_if rsp_if ();

   imu_butterworth_lowpass_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // Q2.30 from a decimal magnitude, rounded half up
   function automatic longint q30(input real mag);
      return longint'($floor(mag * 1073741824.0 + 0.5));
   endfunction

   longint rate_b0 = q30(0.067455273889072);
   longint rate_b1 = q30(0.134910547778144);
   longint rate_a1 = -q30(1.142980502539901);
   longint rate_a2 = q30(0.412801598096189);
   longint accel_b0 = q30(0.018098933007514);
   longint accel_b1 = q30(0.054296799022543);
   longint accel_a1 = -q30(1.760041880343169);
   longint accel_a2 = q30(1.182893262037831);
   longint accel_a3 = -q30(0.278059917634547);

   longint rate_in_past  [3][2];
   longint rate_out_past [3][2];
   longint accel_in_past [3][3];
   longint accel_out_past[3][3];

   imu_set_type filtered_q[$];

   int    error_count  = 0;
   int    cycle_count  = 0;
   int    hold_cycles  = 0;
   int    stall_left   = 0;
   bit    tx_idle_on   = 1'b1;
   bit    rx_idle_on   = 1'b1;
   string axis_name[3] = '{"x", "y", "z"};

   always begin
      #PERIOD_HALF clock = 1'b1;
      #PERIOD_HALF clock = 1'b0;
   end

   function automatic sample_type round_clamp(input longint acc);
      longint y;
      y = (acc + (longint'(1) <<< 29)) >>> 30;
      if (y > SAMPLE_MAX) y = SAMPLE_MAX;
      if (y < SAMPLE_MIN) y = SAMPLE_MIN;
      return sample_type'(y);
   endfunction

   function automatic imu_set_type predict_filtered(input imu_set_type s);
      imu_set_type y;
      longint   acc;
      longint   x;
      for (int i = 0; i < 3; i++) begin
         y.gyro[i]  = '0;
         y.accel[i] = '0;
      end
      for (int i = 0; i < AXES && i < 3; i++) begin
         x   = longint'(s.gyro[i]);
         acc = rate_b0 * x + rate_b1 * rate_in_past[i][0] + rate_b0 * rate_in_past[i][1]
             - rate_a1 * rate_out_past[i][0] - rate_a2 * rate_out_past[i][1];
         y.gyro[i] = round_clamp(acc);
         rate_in_past[i][1]  = rate_in_past[i][0];
         rate_in_past[i][0]  = x;
         rate_out_past[i][1] = rate_out_past[i][0];
         rate_out_past[i][0] = longint'(y.gyro[i]);
      end
      for (int i = 0; i < AXES && i < 3; i++) begin
         x   = longint'(s.accel[i]);
         acc = accel_b0 * x + accel_b1 * accel_in_past[i][0]
             + accel_b1 * accel_in_past[i][1] + accel_b0 * accel_in_past[i][2]
             - accel_a1 * accel_out_past[i][0] - accel_a2 * accel_out_past[i][1]
             - accel_a3 * accel_out_past[i][2];
         y.accel[i] = round_clamp(acc);
         accel_in_past[i][2]  = accel_in_past[i][1];
         accel_in_past[i][1]  = accel_in_past[i][0];
         accel_in_past[i][0]  = x;
         accel_out_past[i][2] = accel_out_past[i][1];
         accel_out_past[i][1] = accel_out_past[i][0];
         accel_out_past[i][0] = longint'(y.accel[i]);
      end
      return y;
   endfunction

   function automatic imu_set_type uniform_set(input sample_type v);
      imu_set_type s;
      for (int i = 0; i < 3; i++) begin
         s.gyro[i]  = v;
         s.accel[i] = v;
      end
      return s;
   endfunction

   function automatic imu_set_type noise_set();
      imu_set_type s;
      for (int i = 0; i < 3; i++) begin
         s.gyro[i]  = sample_type'($urandom);
         s.accel[i] = sample_type'($urandom);
      end
      return s;
   endfunction

   task automatic report_error(input string msg);
      if (error_count < MAX_PRINTS) $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // one request; valid stays up when the next one follows without a gap
   task automatic send_sample(input imu_set_type s);
      int gap;
      gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.gyro_x  <= s.gyro[0];
      req_if.gyro_y  <= s.gyro[1];
      req_if.gyro_z  <= s.gyro[2];
      req_if.accel_x <= s.accel[0];
      req_if.accel_y <= s.accel[1];
      req_if.accel_z <= s.accel[2];
      do @(posedge clock); while (req_if.ready !== 1'b1);
      filtered_q.push_back(predict_filtered(s));
   endtask

   task automatic pause_until_drained();
      req_if.valid <= 1'b0;
      wait (filtered_q.size() == 0);
      @(posedge clock);
   endtask

   // response side: random stalls per response plus an optional long hold
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready)
            stall_left = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_if.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      imu_set_type got;
      imu_set_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         got.gyro[0]  = rsp_if.gyro_filt_x;
         got.gyro[1]  = rsp_if.gyro_filt_y;
         got.gyro[2]  = rsp_if.gyro_filt_z;
         got.accel[0] = rsp_if.accel_filt_x;
         got.accel[1] = rsp_if.accel_filt_y;
         got.accel[2] = rsp_if.accel_filt_z;
         if (filtered_q.size() == 0) begin
            report_error("response with no request outstanding");
         end else begin
            want = filtered_q.pop_front();
            for (int i = 0; i < 3; i++) begin
               if (got.gyro[i] !== want.gyro[i])
                  report_error($sformatf("gyro_filt_%s got %0d want %0d",
                     axis_name[i], got.gyro[i], want.gyro[i]));
               if (got.accel[i] !== want.accel[i])
                  report_error($sformatf("accel_filt_%s got %0d want %0d",
                     axis_name[i], got.accel[i], want.accel[i]));
            end
         end
      end
   end

   initial begin
      while (cycle_count < RUN_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("imu_butterworth_lowpass_top_tb: done, errors");
      $finish;
   end

   task automatic test_field_extremes();
      imu_set_type s;
      send_sample(uniform_set('0));
      send_sample(uniform_set(sample_type'(SAMPLE_MAX)));
      send_sample(uniform_set(sample_type'(SAMPLE_MIN)));
      send_sample(uniform_set(sample_type'(-1)));
      send_sample(uniform_set(sample_type'(1)));
      send_sample(uniform_set(sample_type'(24'hAAAAAA)));
      send_sample(uniform_set(sample_type'(24'h555555)));
      for (int i = 0; i < 3; i++) begin
         s.gyro[i]  = (i % 2) ? sample_type'(SAMPLE_MIN) : sample_type'(SAMPLE_MAX);
         s.accel[i] = (i % 2) ? sample_type'(SAMPLE_MAX) : sample_type'(SAMPLE_MIN);
      end
      send_sample(s);
   endtask

   // full-scale step; filter overshoot drives the outputs into saturation
   task automatic test_step_overshoot();
      repeat (8) send_sample(uniform_set(sample_type'(SAMPLE_MIN)));
      repeat (10) send_sample(uniform_set(sample_type'(SAMPLE_MAX)));
   endtask

   task automatic test_random_noise();
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      repeat (150) send_sample(noise_set());
   endtask

   // slow-moving levels with small noise and occasional jumps
   task automatic test_sensor_streams();
      longint   level[6];
      imu_set_type s;
      for (int k = 0; k < 6; k++) level[k] = 0;
      for (int n = 0; n < 200; n++) begin
         if (n % 25 == 0) begin
            tx_idle_on = 1'($urandom_range(0, 1));
            rx_idle_on = 1'($urandom_range(0, 1));
         end
         for (int k = 0; k < 6; k++) begin
            if ($urandom_range(0, 19) == 0)
               level[k] = longint'(sample_type'($urandom));
            else
               level[k] += longint'($urandom_range(0, 8192)) - 4096;
            if (level[k] > SAMPLE_MAX) level[k] = SAMPLE_MAX;
            if (level[k] < SAMPLE_MIN) level[k] = SAMPLE_MIN;
         end
         for (int i = 0; i < 3; i++) begin
            s.gyro[i]  = sample_type'(level[i]);
            s.accel[i] = sample_type'(level[3 + i]);
         end
         send_sample(s);
      end
   endtask

   task automatic test_output_backpressure();
      tx_idle_on  = 1'b0;
      rx_idle_on  = 1'b0;
      hold_cycles = 80;
      repeat (40) send_sample(noise_set());
   endtask

   task automatic test_drained_bursts();
      for (int b = 0; b < 4; b++) begin
         tx_idle_on = b[0];
         rx_idle_on = b[1];
         repeat (20) send_sample(noise_set());
         pause_until_drained();
      end
   endtask

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_if.valid   <= 1'b0;
      req_if.gyro_x  <= '0;
      req_if.gyro_y  <= '0;
      req_if.gyro_z  <= '0;
      req_if.accel_x <= '0;
      req_if.accel_y <= '0;
      req_if.accel_z <= '0;
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 2; k++) begin
            rate_in_past[i][k]  = 0;
            rate_out_past[i][k] = 0;
         end
         for (int k = 0; k < 3; k++) begin
            accel_in_past[i][k]  = 0;
            accel_out_past[i][k] = 0;
         end
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_field_extremes();
      test_step_overshoot();
      pause_until_drained();
      test_random_noise();
      test_sensor_streams();
      pause_until_drained();
      test_output_backpressure();
      pause_until_drained();
      test_drained_bursts();

      pause_until_drained();
      repeat (8) @(posedge clock);
      if (error_count == 0 && filtered_q.size() == 0) begin
         $display("imu_butterworth_lowpass_top_tb: done, clean");
      end else begin
         $display("imu_butterworth_lowpass_top_tb: done, errors");
      end
      $finish;
   end

endmodule
